### rtl/camhs_pkg.sv
// Package with the shared types and constants of the camera handshake sequencer.
`default_nettype none

package camhs_pkg;

    // Handshake step of one channel.
    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_ARM       = 3'd1,
        ST_WAIT_FREE = 3'd2,
        ST_WAIT_BUSY = 3'd3,
        ST_WAIT_DONE = 3'd4
    } step_t;

    // Request codes on the op field.
    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_INSPECT = 3'd1;
    localparam logic [2:0] OP_RESET   = 3'd2;
    localparam logic [2:0] OP_COMMAND = 3'd3;
    localparam logic [2:0] OP_JOB     = 3'd4;

    // Channel numbers, also the bit positions in the masks.
    localparam logic [1:0] CH_INSPECT = 2'd0;
    localparam logic [1:0] CH_RESET   = 2'd1;
    localparam logic [1:0] CH_COMMAND = 2'd2;
    localparam logic [1:0] CH_JOB     = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_STEP_TIMEOUT  = 3'd0;
    localparam logic [2:0] REG_JOB_TIMEOUT   = 3'd1;
    localparam logic [2:0] REG_RESET_RELEASE = 3'd2;
    localparam logic [2:0] REG_RESET_RETRY   = 3'd3;
    localparam logic [2:0] REG_WATCHDOG_OFF  = 3'd4;

    // Configuration reset values.
    localparam logic [15:0] STEP_TIMEOUT_RST  = 16'd5000;
    localparam logic [15:0] JOB_TIMEOUT_RST   = 16'd15000;
    localparam logic [15:0] RESET_RELEASE_RST = 16'd3500;
    localparam logic [15:0] RESET_RETRY_RST   = 16'd4000;

    localparam logic [15:0] TIMER_MAX = 16'hFFFF;
    localparam logic [7:0]  RETRY_MAX = 8'hFF;

endpackage

`default_nettype wire

### rtl/camera_handshake_sequencer.sv
// Camera handshake sequencer: four handshake channels advanced once per scan tick word.
// A result word passes through the input register, then one pass of channel logic
// into the result register.
// Throughput: one word per cycle; a stalled result holds the input register, which takes one word.
// Reset (aresetn low, synchronous): all channels idle, timers, flags, pass latch and
// retry count cleared, configuration back to its defaults, input and result registers empty.
`default_nettype none

module camera_handshake_sequencer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    // Input words
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_op,
    input  wire logic        s_cam_busy,
    input  wire logic        s_cam_ready,
    input  wire logic        s_cam_pass,
    // Result words
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_inspect_strobe,
    output logic             m_reset_strobe,
    output logic             m_command_strobe,
    output logic             m_job_strobe,
    output logic             m_request_taken,
    output logic [3:0]       m_busy_mask,
    output logic [3:0]       m_timeout_mask,
    output logic             m_inspect_passed,
    output logic [7:0]       m_reset_retries
);

    // Configuration registers
    logic [15:0] step_timeout_reg;
    logic [15:0] job_timeout_reg;
    logic [15:0] reset_release_reg;
    logic [15:0] reset_retry_reg;
    logic        watchdog_off_reg;

    // Input register
    logic        in_valid_reg;
    logic [2:0]  in_op_reg;
    logic        in_busy_reg;
    logic        in_ready_reg;
    logic        in_pass_reg;

    // Channel state
    camhs_pkg::step_t step_reg [4];
    camhs_pkg::step_t step_next [4];
    logic [3:0]       settled_reg;
    logic [3:0]       settled_next;
    logic [15:0]      timer_reg [4];
    logic [15:0]      timer_next [4];
    logic [3:0]       strobe_reg;
    logic [3:0]       strobe_next;
    logic             pass_reg;
    logic             pass_next;
    logic [7:0]       retry_reg;
    logic [7:0]       retry_next;

    // Result register
    logic        out_valid_reg;
    logic [3:0]  out_strobe_reg;
    logic        out_taken_reg;
    logic [3:0]  out_busy_reg;
    logic [3:0]  out_timeout_reg;
    logic        out_pass_reg;
    logic [7:0]  out_retry_reg;

    logic        advance;
    logic        in_accept;
    logic        taken;
    logic [3:0]  timeout_mask;
    logic [3:0]  busy_mask;

    // A word moves into the result register when the result slot is free or being taken.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign in_accept = s_valid && s_ready;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_timeout_reg  <= camhs_pkg::STEP_TIMEOUT_RST;
            job_timeout_reg   <= camhs_pkg::JOB_TIMEOUT_RST;
            reset_release_reg <= camhs_pkg::RESET_RELEASE_RST;
            reset_retry_reg   <= camhs_pkg::RESET_RETRY_RST;
            watchdog_off_reg  <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                camhs_pkg::REG_STEP_TIMEOUT:  step_timeout_reg  <= cfg_wdata;
                camhs_pkg::REG_JOB_TIMEOUT:   job_timeout_reg   <= cfg_wdata;
                camhs_pkg::REG_RESET_RELEASE: reset_release_reg <= cfg_wdata;
                camhs_pkg::REG_RESET_RETRY:   reset_retry_reg   <= cfg_wdata;
                camhs_pkg::REG_WATCHDOG_OFF:  watchdog_off_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_op_reg    <= s_op;
            in_busy_reg  <= s_cam_busy;
            in_ready_reg <= s_cam_ready;
            in_pass_reg  <= s_cam_pass;
        end
    end

    // One tick of all four channels: apply the request, then step each channel.
    always_comb begin
        logic [2:0]       op_m1;
        camhs_pkg::step_t stp;
        camhs_pkg::step_t nstp;
        logic             set;
        logic             nset;
        logic [15:0]      t;
        logic [15:0]      limit;
        logic             strb;
        logic             is_rst;
        logic             is_job;
        logic             r13;
        logic             run;

        step_next    = step_reg;
        settled_next = settled_reg;
        timer_next   = timer_reg;
        strobe_next  = strobe_reg;
        pass_next    = pass_reg;
        retry_next   = retry_reg;
        taken        = 1'b0;
        timeout_mask = 4'b0;
        busy_mask    = 4'b0;
        op_m1        = in_op_reg - 3'd1;
        stp          = camhs_pkg::ST_IDLE;
        nstp         = camhs_pkg::ST_IDLE;
        set          = 1'b0;
        nset         = 1'b0;
        t            = '0;
        limit        = '0;
        strb         = 1'b0;
        is_rst       = 1'b0;
        is_job       = 1'b0;
        r13          = 1'b0;
        run          = 1'b0;

        if (advance) begin
            // Request: job change ignores the ready line, the others need it.
            if (in_op_reg >= camhs_pkg::OP_INSPECT && in_op_reg <= camhs_pkg::OP_JOB) begin
                if (in_op_reg == camhs_pkg::OP_JOB || in_ready_reg) begin
                    step_next[op_m1[1:0]]    = camhs_pkg::ST_ARM;
                    settled_next[op_m1[1:0]] = 1'b0;
                    taken                    = 1'b1;
                end
            end

            for (int c = 0; c < 4; c++) begin
                stp  = step_next[c];
                set  = settled_next[c];
                t    = timer_reg[c];
                strb = strobe_reg[c];
                if (stp != camhs_pkg::ST_IDLE) begin
                    is_rst = (2'(c) == camhs_pkg::CH_RESET);
                    is_job = (2'(c) == camhs_pkg::CH_JOB);
                    r13    = is_rst && (stp == camhs_pkg::ST_WAIT_DONE);
                    run    = set && !watchdog_off_reg;

                    // On-delay timer; the reset wait counts even with the watchdog off.
                    if (set && (!watchdog_off_reg || r13)) begin
                        t = (t == camhs_pkg::TIMER_MAX) ? t : t + 16'd1;
                    end else if (r13) begin
                        t = 16'd1;
                    end else begin
                        t = '0;
                    end
                    limit = is_job ? job_timeout_reg : step_timeout_reg;

                    if (run && t >= limit) begin
                        // Watchdog: drop the line and idle; the settled flag is kept.
                        strb            = 1'b0;
                        nstp            = camhs_pkg::ST_IDLE;
                        nset            = set;
                        timeout_mask[c] = 1'b1;
                    end else begin
                        nstp = stp;
                        unique case (stp)
                            camhs_pkg::ST_ARM: begin
                                strb = 1'b0;
                                if (is_rst) begin
                                    retry_next = '0;
                                end
                                nstp = camhs_pkg::ST_WAIT_FREE;
                            end
                            camhs_pkg::ST_WAIT_FREE: begin
                                if (is_rst) begin
                                    nstp = camhs_pkg::ST_WAIT_BUSY;
                                end else if (!in_busy_reg) begin
                                    strb = 1'b1;
                                    nstp = camhs_pkg::ST_WAIT_BUSY;
                                end
                            end
                            camhs_pkg::ST_WAIT_BUSY: begin
                                if (is_rst) begin
                                    strb = 1'b1;
                                    t    = '0;
                                    nstp = camhs_pkg::ST_WAIT_DONE;
                                end else if (in_busy_reg) begin
                                    strb = 1'b0;
                                    nstp = camhs_pkg::ST_WAIT_DONE;
                                end
                            end
                            camhs_pkg::ST_WAIT_DONE: begin
                                if (is_rst) begin
                                    if (t >= reset_release_reg) begin
                                        strb = 1'b0;
                                    end
                                    if (t >= reset_retry_reg) begin
                                        nstp = camhs_pkg::ST_WAIT_FREE;
                                        if (retry_reg != camhs_pkg::RETRY_MAX) begin
                                            retry_next = retry_reg + 8'd1;
                                        end
                                    end
                                    // Busy low ends the reset even on a retry tick.
                                    if (!in_busy_reg) begin
                                        strb = 1'b0;
                                        nstp = camhs_pkg::ST_IDLE;
                                    end
                                end else if (!in_busy_reg) begin
                                    if (2'(c) == camhs_pkg::CH_INSPECT) begin
                                        pass_next = in_pass_reg;
                                    end
                                    nstp = camhs_pkg::ST_IDLE;
                                end
                            end
                            default: begin
                                strb = 1'b0;
                                nstp = camhs_pkg::ST_IDLE;
                            end
                        endcase
                        nset = (nstp == stp);
                    end
                    step_next[c]    = nstp;
                    settled_next[c] = nset;
                    timer_next[c]   = t;
                    strobe_next[c]  = strb;
                end
            end
        end

        for (int c = 0; c < 4; c++) begin
            busy_mask[c] = (step_next[c] != camhs_pkg::ST_IDLE);
        end
    end

    // Channel state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < 4; c++) begin
                step_reg[c]  <= camhs_pkg::ST_IDLE;
                timer_reg[c] <= '0;
            end
            settled_reg <= '0;
            strobe_reg  <= '0;
            pass_reg    <= 1'b0;
            retry_reg   <= '0;
        end else begin
            step_reg    <= step_next;
            timer_reg   <= timer_next;
            settled_reg <= settled_next;
            strobe_reg  <= strobe_next;
            pass_reg    <= pass_next;
            retry_reg   <= retry_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_strobe_reg  <= strobe_next;
            out_taken_reg   <= taken;
            out_busy_reg    <= busy_mask;
            out_timeout_reg <= timeout_mask;
            out_pass_reg    <= pass_next;
            out_retry_reg   <= retry_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_inspect_strobe = out_strobe_reg[camhs_pkg::CH_INSPECT];
    assign m_reset_strobe   = out_strobe_reg[camhs_pkg::CH_RESET];
    assign m_command_strobe = out_strobe_reg[camhs_pkg::CH_COMMAND];
    assign m_job_strobe     = out_strobe_reg[camhs_pkg::CH_JOB];
    assign m_request_taken  = out_taken_reg;
    assign m_busy_mask      = out_busy_reg;
    assign m_timeout_mask   = out_timeout_reg;
    assign m_inspect_passed = out_pass_reg;
    assign m_reset_retries  = out_retry_reg;

endmodule

`default_nettype wire

### rtl/camhs_checker.sv
// Port-level assertions for the camera handshake sequencer and their bind.
`default_nettype none

module camhs_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_inspect_strobe,
    input wire logic        m_reset_strobe,
    input wire logic        m_command_strobe,
    input wire logic        m_job_strobe,
    input wire logic        m_request_taken,
    input wire logic [3:0]  m_busy_mask,
    input wire logic [3:0]  m_timeout_mask,
    input wire logic [7:0]  m_reset_retries
);

    // A stalled result word holds.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_busy_mask)
            && $stable(m_reset_retries))
        else $error("result word changed while stalled");

    // A channel that timed out is idle in the same word.
    a_timeout_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_timeout_mask & m_busy_mask) == 4'b0)
        else $error("timed out channel still busy");

    // A taken request leaves at least one channel busy.
    a_taken_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_request_taken |-> m_busy_mask != 4'b0)
        else $error("request taken but no channel busy");

    // A line is driven only while its channel is busy.
    a_strobe_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({m_job_strobe, m_command_strobe, m_reset_strobe, m_inspect_strobe}
            & ~m_busy_mask) == 4'b0)
        else $error("strobe high on an idle channel");

endmodule

bind camera_handshake_sequencer camhs_checker u_camhs_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_inspect_strobe (m_inspect_strobe),
    .m_reset_strobe   (m_reset_strobe),
    .m_command_strobe (m_command_strobe),
    .m_job_strobe     (m_job_strobe),
    .m_request_taken  (m_request_taken),
    .m_busy_mask      (m_busy_mask),
    .m_timeout_mask   (m_timeout_mask),
    .m_reset_retries  (m_reset_retries)
);

`default_nettype wire
